// ----- rtl/proe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Octal escaper package
// Shared widths, character constants, the result item type and the escape
// character formatter.
// ----------------------------------------------------------------------------
package proe_pkg;

   localparam int BYTE_W      = 8;
   localparam int THR_W       = 4;
   localparam int MAX_RUN_DEF = 15;
   localparam int ESC_LEN     = 4;
   localparam int DIGIT_W     = $clog2(ESC_LEN);

   localparam logic [THR_W-1:0]   THR_RESET      = 4'd4;
   localparam logic [BYTE_W-1:0]  PRINT_LOW      = 8'h20;
   localparam logic [BYTE_W-1:0]  PRINT_HIGH     = 8'h7E;
   localparam logic [BYTE_W-1:0]  ESC_CHAR       = 8'h5C;
   localparam logic [BYTE_W-1:0]  DIGIT_BASE     = 8'h30;
   localparam logic [DIGIT_W-1:0] DIGIT_LEAD     = 2'd0;
   localparam logic [DIGIT_W-1:0] DIGIT_HIGH     = 2'd1;
   localparam logic [DIGIT_W-1:0] DIGIT_MID      = 2'd2;
   localparam logic [DIGIT_W-1:0] DIGIT_LOW      = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] out_char;
      logic              out_last;
   } out_item_type;

   // One character of the backslash and three octal digit form of a byte.
   function automatic logic [BYTE_W-1:0] esc_char(input logic [BYTE_W-1:0]  b,
                                                  input logic [DIGIT_W-1:0] digit);
      logic [BYTE_W-1:0] c;
      unique case (digit)
         DIGIT_LEAD: c = ESC_CHAR;
         DIGIT_HIGH: c = DIGIT_BASE + {6'd0, b[7:6]};
         DIGIT_MID:  c = DIGIT_BASE + {5'd0, b[5:3]};
         default:    c = DIGIT_BASE + {5'd0, b[2:0]};
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/proe_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Octal escaper channels
// Valid/ready interfaces for the byte request channel and the character
// response channel.
// ----------------------------------------------------------------------------
interface proe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface proe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink   (input valid, input out_char, input out_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/proe_run_buffer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Held run buffer
// Synchronous memory of the printable bytes held in the current run, one
// write and one registered read per cycle.
// ----------------------------------------------------------------------------
module proe_run_buffer #(
   parameter int MAX_RUN = proe_pkg::MAX_RUN_DEF,
   parameter int ADDR_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1
) (
   input  wire                        clock,
   input  wire                        wr_en,
   input  wire  [ADDR_W-1:0]          wr_addr,
   input  wire  [proe_pkg::BYTE_W-1:0] wr_data,
   input  wire                        rd_en,
   input  wire  [ADDR_W-1:0]          rd_addr,
   output logic [proe_pkg::BYTE_W-1:0] rd_data_ff
);
   import proe_pkg::*;

   logic [BYTE_W-1:0] mem [MAX_RUN];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Entries are read only after the accept cycle that wrote them.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/proe_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Response output register
// Holds one character for the response channel and takes a new one in the
// cycle the current one is taken.
// ----------------------------------------------------------------------------
module proe_out_stage (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push_valid,
   input  proe_pkg::out_item_type  push_item,
   output logic                    push_ready,
   proe_rsp_if.source              rsp_ch
);
   import proe_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   out_item_type item_ff;

   assign push_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (push_ready) begin
         valid_in = push_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid && push_ready) begin
         item_ff <= push_item;
      end
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.out_char = item_ff.out_char;
   assign rsp_ch.out_last = item_ff.out_last;

endmodule
`default_nettype wire

// ----- rtl/printable_run_octal_escaper.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Printable run octal escaper
// Escapes all non-printable bytes, and short printable runs that one ends,
// as a backslash and three octal digits; other printable runs pass literally.
// ----------------------------------------------------------------------------
// Usage:
// Each request on req_ch carries one byte and a flag on the last byte of the
// string. Each response on rsp_ch carries one character; out_last marks the
// final character produced for a string. csr_wr_en/csr_wr_data set the run
// threshold; the user must write it only while the block is idle, which the
// block does not enforce. A printable byte that is held produces nothing and
// the block is ready again in the next cycle. A byte in a run already released
// passes straight out. When a run is released, the held run memory is read
// one entry per fetch: a literal byte goes through a fetch and an emit, an
// escaped byte through a fetch and four characters. A non-printable byte then
// adds the four characters of its own escape. The sequencer and the single
// read port of the run memory set the pace; the block takes no new request
// until the current one is emitted. The first response for a byte that passes
// straight through or a lone escape goes through the sequencer state and then
// the output register; when the held run is read first, the registered memory
// read lies between them. Reset clears the held count, the pass-through flag
// and the response valid, and sets the threshold to 4; the run memory needs no
// clearing. When the receiver stalls, the output register holds its character
// and the sequencer waits in place.
// ----------------------------------------------------------------------------
module printable_run_octal_escaper #(
   parameter int MAX_RUN = proe_pkg::MAX_RUN_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_wr_en,
   input  wire  [proe_pkg::THR_W-1:0] csr_wr_data,
   proe_req_if.sink                   req_ch,
   proe_rsp_if.source                 rsp_ch
);
   import proe_pkg::*;

   localparam int CNT_W  = $clog2(MAX_RUN + 1);
   localparam int ADDR_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RUN);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_EMIT  = 3'd2;
   localparam logic [2:0] ST_TAIL  = 3'd3;
   localparam logic [2:0] ST_PASS  = 3'd4;

   // Control state.
   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               passing_ff, passing_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;

   // Per request context, loaded at acceptance.
   logic [BYTE_W-1:0]  byte_ff;
   logic               eos_ff;
   logic               tail_ff;
   logic               escape_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               load_ctx;
   logic               tail_in;
   logic               escape_in;
   logic [CNT_W-1:0]   cnt_in;

   logic               accept;
   logic               printable;
   logic [CNT_W-1:0]   thr_sat;
   logic [CNT_W-1:0]   held_next;
   logic               release_run;
   logic               wr_en;
   logic               rd_en;
   logic [BYTE_W-1:0]  rd_data;

   logic               entry_done;
   logic               final_entry;
   logic               push_valid;
   logic               push_ready;
   out_item_type       push_item;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign printable    = (req_ch.in_byte >= PRINT_LOW) && (req_ch.in_byte <= PRINT_HIGH);

   // Threshold above the buffer size saturates so the buffer never overflows.
   assign thr_sat     = (32'(thr_ff) > MAX_RUN) ? MAX_CNT : CNT_W'(thr_ff);
   assign held_next   = (count_ff < MAX_CNT) ? CNT_W'(count_ff + 1'b1) : count_ff;
   assign release_run = (held_next >= thr_sat);
   assign wr_en       = accept && printable && !passing_ff && (count_ff < MAX_CNT);
   assign rd_en       = (state_ff == ST_FETCH);

   proe_run_buffer #(
      .MAX_RUN (MAX_RUN),
      .ADDR_W  (ADDR_W)
   ) u_run_buffer (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[ADDR_W-1:0]),
      .wr_data    (req_ch.in_byte),
      .rd_en      (rd_en),
      .rd_addr    (idx_ff[ADDR_W-1:0]),
      .rd_data_ff (rd_data)
   );

   assign entry_done  = !escape_ff || (digit_ff == DIGIT_LOW);
   assign final_entry = (CNT_W'(idx_ff + 1'b1) == cnt_ff);

   // Character produced in the current sequencer state.
   always_comb begin
      push_valid         = 1'b0;
      push_item.out_char = byte_ff;
      push_item.out_last = 1'b0;
      unique case (state_ff)
         ST_EMIT: begin
            push_valid         = 1'b1;
            push_item.out_char = escape_ff ? esc_char(rd_data, digit_ff) : rd_data;
            push_item.out_last = eos_ff && !tail_ff && entry_done && final_entry;
         end
         ST_TAIL: begin
            push_valid         = 1'b1;
            push_item.out_char = esc_char(byte_ff, digit_ff);
            push_item.out_last = eos_ff && (digit_ff == DIGIT_LOW);
         end
         ST_PASS: begin
            push_valid         = 1'b1;
            push_item.out_last = eos_ff;
         end
         default: begin
         end
      endcase
   end

   // Sequencer: decides the job at acceptance, then walks the held run and
   // the trailing escape one character at a time, waiting while the output is full.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      passing_in = passing_ff;
      idx_in     = idx_ff;
      digit_in   = digit_ff;
      load_ctx   = 1'b0;
      tail_in    = 1'b0;
      escape_in  = 1'b0;
      cnt_in     = count_ff;
      thr_in     = csr_wr_en ? csr_wr_data : thr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load_ctx = 1'b1;
               idx_in   = '0;
               digit_in = DIGIT_LEAD;
               if (printable && passing_ff) begin
                  // Run already released: the byte goes straight out.
                  state_in   = ST_PASS;
                  passing_in = !req_ch.end_of_string;
               end else if (printable) begin
                  if (release_run || req_ch.end_of_string) begin
                     state_in   = ST_FETCH;
                     cnt_in     = held_next;
                     count_in   = '0;
                     passing_in = release_run && !req_ch.end_of_string;
                  end else begin
                     count_in = held_next;
                  end
               end else begin
                  // Non-printable: escape the short run if any, then the byte.
                  tail_in    = 1'b1;
                  escape_in  = 1'b1;
                  count_in   = '0;
                  passing_in = 1'b0;
                  if (!passing_ff && (count_ff != '0)) begin
                     state_in = ST_FETCH;
                  end else begin
                     state_in = ST_TAIL;
                  end
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (push_ready) begin
               if (entry_done) begin
                  digit_in = DIGIT_LEAD;
                  if (final_entry) begin
                     state_in = tail_ff ? ST_TAIL : ST_IDLE;
                  end else begin
                     idx_in   = CNT_W'(idx_ff + 1'b1);
                     state_in = ST_FETCH;
                  end
               end else begin
                  digit_in = digit_ff + 1'b1;
               end
            end
         end
         ST_TAIL: begin
            if (push_ready) begin
               if (digit_ff == DIGIT_LOW) begin
                  digit_in = DIGIT_LEAD;
                  state_in = ST_IDLE;
               end else begin
                  digit_in = digit_ff + 1'b1;
               end
            end
         end
         ST_PASS: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         passing_ff <= 1'b0;
         thr_ff     <= THR_RESET;
         idx_ff     <= '0;
         digit_ff   <= DIGIT_LEAD;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         passing_ff <= passing_in;
         thr_ff     <= thr_in;
         idx_ff     <= idx_in;
         digit_ff   <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ctx) begin
         byte_ff   <= req_ch.in_byte;
         eos_ff    <= req_ch.end_of_string;
         tail_ff   <= tail_in;
         escape_ff <= escape_in;
         cnt_ff    <= cnt_in;
      end
   end

   proe_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octal escaper testbench
// Drives byte requests into the printable run octal escaper and checks each
// response character against typed text or a predictor of the escaping
// rules. A short directed table comes first, then random strings across
// several threshold and flow control phases.
// ----------------------------------------------------------------------------
module testbench;
   import proe_pkg::*;

   localparam int RUN_DEPTH    = MAX_RUN_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 37;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_SETTLE  = 8;

   // Directed table rows either send a byte or retune the run threshold.
   typedef enum {ROW_BYTE, ROW_THR} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [7:0]       value;
      logic             eos;
      bit               typed;
      string            text;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [THR_W-1:0] csr_wr_data;

   proe_req_if req_if ();
   proe_rsp_if rsp_if ();

   printable_run_octal_escaper u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if)
   );

   // Predictor state: the held run, its length, whether the current run has
   // already gone out literally, and the threshold as last written.
   logic [7:0]       run_buf [RUN_DEPTH];
   int               run_len;
   bit               literal_mode;
   logic [THR_W-1:0] esc_threshold;

   // Characters produced by the most recent prediction, and the characters
   // still owed by the block, oldest first.
   out_item_type     pred_chars[$];
   out_item_type     pending_chars[$];

   int               err_count;
   int               cycle_count;
   int               idle_pct;
   int               stall_pct;
   int               items_sent;

   stim_row_type     stim_rows[26];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   task automatic push_char(input logic [7:0] c);
      out_item_type item;
      item.out_char = c;
      item.out_last = 1'b0;
      pred_chars.push_back(item);
   endtask

   // A backslash and the byte's three octal digits, most significant first.
   task automatic push_octal(input logic [7:0] b);
      push_char(ESC_CHAR);
      push_char(DIGIT_BASE + {6'd0, b[7:6]});
      push_char(DIGIT_BASE + {5'd0, b[5:3]});
      push_char(DIGIT_BASE + {5'd0, b[2:0]});
   endtask

   task automatic release_run_literal();
      int i;
      for (i = 0; i < run_len; i++) push_char(run_buf[i]);
      run_len = 0;
   endtask

   // Works out every character one request produces and advances the state.
   task automatic predict_escape(input logic [7:0] b, input logic eos);
      int eff_thr;
      int i;
      pred_chars.delete();
      // The threshold saturates at the buffer depth, so a zero threshold
      // releases every printable byte at once.
      eff_thr = (int'(esc_threshold) > RUN_DEPTH) ? RUN_DEPTH : int'(esc_threshold);
      if (b >= PRINT_LOW && b <= PRINT_HIGH) begin
         if (literal_mode) begin
            push_char(b);
         end else begin
            if (run_len < RUN_DEPTH) begin
               run_buf[run_len] = b;
               run_len++;
            end
            if (run_len >= eff_thr) begin
               release_run_literal();
               literal_mode = 1'b1;
            end
         end
      end else begin
         // A control or high byte ends the run: a short held run goes out
         // escaped, then the byte itself always does.
         if (!literal_mode) begin
            for (i = 0; i < run_len; i++) push_octal(run_buf[i]);
         end
         run_len = 0;
         literal_mode = 1'b0;
         push_octal(b);
      end
      if (eos) begin
         // A run still held at the end of the string is released unchanged.
         if (!literal_mode) release_run_literal();
         run_len = 0;
         literal_mode = 1'b0;
         if (pred_chars.size() > 0) pred_chars[pred_chars.size() - 1].out_last = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= 10) $display("%s", msg);
   endtask

   // Sends one request, with a random number of idle cycles ahead of it. The
   // expectation is either typed in by the caller or taken from the predictor.
   task automatic send_request(input logic [7:0] b, input logic eos,
                               input bit typed, input string text);
      out_item_type item;
      int i;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid         <= 1'b1;
      req_if.in_byte       <= b;
      req_if.end_of_string <= eos;
      do @(posedge clock); while (!req_if.ready);
      predict_escape(b, eos);
      if (typed) begin
         for (i = 0; i < text.len(); i++) begin
            item.out_char = text[i];
            item.out_last = eos && (i == text.len() - 1);
            pending_chars.push_back(item);
         end
      end else begin
         foreach (pred_chars[i]) pending_chars.push_back(pred_chars[i]);
      end
   endtask

   // Holds the sender off until every owed character has come back. A held
   // byte owes nothing, so a further settling wait lets the block come to rest after it.
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [THR_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      esc_threshold = value;
   endtask

   function automatic logic [7:0] rand_printable();
      return 8'($urandom_range(PRINT_HIGH, PRINT_LOW));
   endfunction

   function automatic logic [7:0] rand_control();
      if ($urandom_range(1) == 1) return 8'($urandom_range(PRINT_LOW - 1, 0));
      return 8'($urandom_range(255, PRINT_HIGH + 1));
   endfunction

   // One string: mostly printable runs sized around the threshold, closed by a
   // control or high byte (the last at random), or now and then short noise.
   task automatic send_random_string(input int thr);
      logic [7:0] str_q[$];
      int segs;
      int run;
      int k;
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(6, 1)) str_q.push_back(8'($urandom_range(255)));
      end else begin
         segs = $urandom_range(3, 1);
         for (k = 0; k < segs; k++) begin
            case ($urandom_range(3))
               0: begin
                  run = (thr > 0) ? thr - 1 : 0;
               end
               1: begin
                  run = thr;
               end
               2: begin
                  run = thr + $urandom_range(3, 1);
               end
               default: begin
                  run = $urandom_range(16);
               end
            endcase
            repeat (run) str_q.push_back(rand_printable());
            if (k < segs - 1 || $urandom_range(1) == 1) str_q.push_back(rand_control());
         end
         if (str_q.size() == 0) str_q.push_back(rand_control());
      end
      for (k = 0; k < str_q.size(); k++) begin
         send_request(str_q[k], k == str_q.size() - 1, 1'b0, "");
      end
      items_sent += str_q.size();
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls on ready, and the in-order character check.
   // ------------------------------------------------------------------------
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      out_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_chars.size() == 0) begin
            flag_error($sformatf("unexpected response: out_char=%02h out_last=%0b",
                                 rsp_if.out_char, rsp_if.out_last));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_if.out_char !== want.out_char) begin
               flag_error($sformatf("out_char mismatch: expected %02h, got %02h",
                                    want.out_char, rsp_if.out_char));
            end
            if (rsp_if.out_last !== want.out_last) begin
               flag_error($sformatf("out_last mismatch on %02h: expected %0b, got %0b",
                                    want.out_char, want.out_last, rsp_if.out_last));
            end
         end
      end
   end

   // A hung handshake ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int r;
      int ph;
      int phase_start;
      logic [THR_W-1:0] thr;

      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_if.valid         = 1'b0;
      req_if.in_byte       = '0;
      req_if.end_of_string = 1'b0;
      err_count            = 0;
      idle_pct             = 0;
      stall_pct            = 0;
      items_sent           = 0;
      run_len              = 0;
      literal_mode         = 1'b0;
      esc_threshold        = THR_RESET;

      // Rows with a typed text show exactly what should come back; the rest
      // are left to the predictor. The threshold is 4 out of reset.
      stim_rows = '{
         '{ROW_BYTE, 8'h00, 1'b1, 1'b1, "\\000"},           // lowest byte
         '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, "\\377"},           // highest byte
         '{ROW_BYTE, 8'h7F, 1'b1, 1'b1, "\\177"},           // DEL, just above printable
         '{ROW_BYTE, 8'h1F, 1'b0, 1'b1, "\\037"},           // just below printable
         '{ROW_BYTE, 8'h20, 1'b0, 1'b1, ""},                // space is held
         '{ROW_BYTE, 8'h7E, 1'b0, 1'b1, ""},                // tilde is held
         '{ROW_BYTE, 8'h80, 1'b1, 1'b1, "\\040\\176\\200"}, // short run escaped
         '{ROW_BYTE, 8'h41, 1'b0, 1'b1, ""},
         '{ROW_BYTE, 8'h42, 1'b0, 1'b1, ""},
         '{ROW_BYTE, 8'h43, 1'b0, 1'b1, ""},
         '{ROW_BYTE, 8'h44, 1'b0, 1'b1, "ABCD"},            // run reaches threshold
         '{ROW_BYTE, 8'h45, 1'b1, 1'b1, "E"},               // passes straight through
         '{ROW_BYTE, 8'h78, 1'b1, 1'b1, "x"},               // held run released at end
         '{ROW_BYTE, 8'h61, 1'b0, 1'b1, ""},
         '{ROW_BYTE, 8'h0A, 1'b1, 1'b1, "\\141\\012"},
         '{ROW_THR,  8'h00, 1'b0, 1'b0, ""},                // threshold zero
         '{ROW_BYTE, 8'h5A, 1'b0, 1'b1, "Z"},
         '{ROW_BYTE, 8'h7E, 1'b1, 1'b1, "~"},
         '{ROW_BYTE, 8'h09, 1'b1, 1'b1, "\\011"},
         '{ROW_THR,  8'h01, 1'b0, 1'b0, ""},
         '{ROW_BYTE, 8'h5C, 1'b0, 1'b0, ""},                // a literal backslash
         '{ROW_BYTE, 8'h1B, 1'b1, 1'b0, ""},
         '{ROW_THR,  8'h0F, 1'b0, 1'b0, ""},                // largest threshold
         '{ROW_BYTE, 8'h6B, 1'b0, 1'b0, ""},
         '{ROW_BYTE, 8'h6C, 1'b0, 1'b0, ""},
         '{ROW_BYTE, 8'h6D, 1'b1, 1'b0, ""}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < $size(stim_rows); r++) begin
         if (stim_rows[r].kind == ROW_THR) begin
            wait_drained();
            set_threshold(stim_rows[r].value[THR_W-1:0]);
         end else begin
            send_request(stim_rows[r].value, stim_rows[r].eos,
                         stim_rows[r].typed, stim_rows[r].text);
            items_sent++;
         end
      end

      // Random phases. Each one starts from a drained block, writes its own
      // threshold and has its own mix of sender idling and receiver stalls.
      for (ph = 0; ph < 4; ph++) begin
         wait_drained();
         case (ph)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
               thr       = 4'd15;
            end
            1: begin
               idle_pct  = 62;
               stall_pct = 0;
               thr       = THR_W'($urandom_range(14, 2));
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 62;
               thr       = 4'd1;
            end
            default: begin
               idle_pct  = 33;
               stall_pct = 33;
               thr       = THR_W'($urandom_range(15));
            end
         endcase
         set_threshold(thr);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_random_string(int'(thr));
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ----- printable_run_octal_escaper.f -----
rtl/proe_pkg.sv
rtl/proe_ifs.sv
rtl/proe_run_buffer.sv
rtl/proe_out_stage.sv
rtl/printable_run_octal_escaper.sv
tb/testbench.sv
